>>> design/tlvd_pkg.sv
package tlvd_pkg;

    localparam int unsigned LEN_BYTES_KEPT = 4;
    localparam int unsigned LEN_POS_W = 7;
    localparam logic [7:0] PTR_FLAG_MASK = 8'h80;
    localparam logic [6:0] LOW7_MASK = 7'h7F;

    typedef enum logic [1:0] {
        PH_TAG = 2'd0,
        PH_LEN = 2'd1,
        PH_EXT = 2'd2,
        PH_VAL = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_TAG     = 2'd0,
        KIND_LEN_HDR = 2'd1,
        KIND_LEN_EXT = 2'd2,
        KIND_VALUE   = 2'd3
    } byte_kind_t;

    typedef struct packed {
        byte_kind_t  byte_kind;
        logic [6:0]  record_tag;
        logic        pointer_flag;
        logic [7:0]  payload_byte;
        logic [31:0] value_index;
        logic [31:0] record_length;
        logic        record_done;
        logic        status;
    } result_t;

endpackage

>>> design/tlvd_if.sv
interface tlvd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;
    logic       buffer_end;

    modport source (output valid, output stream_byte, output buffer_end, input ready);
    modport sink   (input valid, input stream_byte, input buffer_end, output ready);
endinterface

interface tlvd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  byte_kind;
    logic [6:0]  record_tag;
    logic        pointer_flag;
    logic [7:0]  payload_byte;
    logic [31:0] value_index;
    logic [31:0] record_length;
    logic        record_done;
    logic        status;

    modport source (
        output valid, output byte_kind, output record_tag, output pointer_flag,
        output payload_byte, output value_index, output record_length,
        output record_done, output status, input ready
    );
    modport sink (
        input valid, input byte_kind, input record_tag, input pointer_flag,
        input payload_byte, input value_index, input record_length,
        input record_done, input status, output ready
    );
endinterface

>>> design/tlv_stream_deframer.sv
// TLV stream deframer.
// The din channel takes one word per cycle: a byte of a TLV buffer and a flag
// that marks the last byte of the buffer. For every accepted word the dout
// channel delivers exactly one word that classifies the byte as tag, length
// header, extra length byte or value byte, together with the record's tag,
// pointer flag, decoded length, value offset, an end-of-record flag and a
// truncation status.
// Results are registered, in the skid register when the result register is
// held by a stall. Throughput is one word per cycle while dout.ready stays
// high; the parse state needs only one small update per byte (a 32-bit
// increment and compare on value bytes, a byte merge on length bytes).
// The output side holds a result register and a one-word skid register, so
// din.ready depends only on a register and not on dout.ready. When the
// receiver stalls, one more word is taken into the skid register, after which
// din.ready drops until the receiver takes a word again.
// Reset clears the parser to expect a tag byte and empties both output
// registers; nothing is lost or repeated across a stall.
module tlv_stream_deframer (
    input  logic clk,
    input  logic rst_n,
    tlvd_in_if.sink    din,
    tlvd_out_if.source dout
);
    import tlvd_pkg::*;

    // Parse state.
    phase_t                 phase_reg, phase_next;
    logic [6:0]             tag_reg, tag_next;
    logic                   ptr_reg, ptr_next;
    logic [LEN_POS_W-1:0]   left_reg, left_next;
    logic [LEN_POS_W-1:0]   pos_reg, pos_next;
    logic [31:0]            accum_reg, accum_next;
    logic [31:0]            vpos_reg, vpos_next;

    // Output stage: main register plus skid register.
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;

    result_t res;
    logic    accept;
    logic    pop;
    logic    done;
    logic [31:0] vpos_inc;
    logic [31:0] merged;

    assign accept = din.valid && din.ready;
    assign pop    = dout.valid && dout.ready;
    assign din.ready = !skid_valid_reg;
    assign vpos_inc  = vpos_reg + 32'd1;

    // Place an extra length byte at its position, least significant first.
    // Only the first four byte positions fit into the 32-bit length.
    always_comb
    begin
        merged = accum_reg;
        if (pos_reg < LEN_POS_W'(LEN_BYTES_KEPT) && pos_reg < LEN_POS_W'(4))
        begin
            unique case (pos_reg[1:0])
                2'd0:    merged = accum_reg | {24'd0, din.stream_byte};
                2'd1:    merged = accum_reg | {16'd0, din.stream_byte, 8'd0};
                2'd2:    merged = accum_reg | {8'd0, din.stream_byte, 16'd0};
                default: merged = accum_reg | {din.stream_byte, 24'd0};
            endcase
        end
    end

    // Classify the incoming byte and work out the next parse state.
    always_comb
    begin
        phase_next = phase_reg;
        tag_next   = tag_reg;
        ptr_next   = ptr_reg;
        left_next  = left_reg;
        pos_next   = pos_reg;
        accum_next = accum_reg;
        vpos_next  = vpos_reg;
        done       = 1'b0;

        res.byte_kind     = KIND_TAG;
        res.record_tag    = tag_reg;
        res.pointer_flag  = ptr_reg;
        res.payload_byte  = din.stream_byte;
        res.value_index   = 32'd0;
        res.record_length = 32'd0;

        unique case (phase_reg)
            PH_TAG:
            begin
                ptr_next   = (din.stream_byte & PTR_FLAG_MASK) != 8'd0;
                tag_next   = din.stream_byte[6:0] & LOW7_MASK;
                accum_next = 32'd0;
                vpos_next  = 32'd0;
                phase_next = PH_LEN;
                res.byte_kind    = KIND_TAG;
                res.record_tag   = tag_next;
                res.pointer_flag = ptr_next;
            end
            PH_LEN:
            begin
                res.byte_kind = KIND_LEN_HDR;
                pos_next  = '0;
                vpos_next = 32'd0;
                if (din.stream_byte[7])
                begin
                    // Extended form: low bits count the extra length bytes.
                    left_next  = din.stream_byte[6:0];
                    accum_next = 32'd0;
                    if (din.stream_byte[6:0] == 7'd0)
                        done = 1'b1;
                    else
                        phase_next = PH_EXT;
                end
                else
                begin
                    accum_next = {24'd0, din.stream_byte};
                    if (din.stream_byte == 8'd0)
                        done = 1'b1;
                    else
                        phase_next = PH_VAL;
                end
                res.record_length = accum_next;
            end
            PH_EXT:
            begin
                res.byte_kind = KIND_LEN_EXT;
                accum_next = merged;
                pos_next   = pos_reg + LEN_POS_W'(1);
                left_next  = left_reg - LEN_POS_W'(1);
                if (left_next == '0)
                begin
                    if (merged == 32'd0)
                        done = 1'b1;
                    else
                    begin
                        phase_next = PH_VAL;
                        vpos_next  = 32'd0;
                    end
                end
                res.record_length = merged;
            end
            default:
            begin
                res.byte_kind     = KIND_VALUE;
                res.value_index   = vpos_reg;
                res.record_length = accum_reg;
                vpos_next = vpos_inc;
                if (vpos_inc == accum_reg)
                    done = 1'b1;
            end
        endcase

        res.record_done = done;
        res.status      = din.buffer_end && !done;

        // End of a record or of the buffer: back to expecting a tag byte.
        if (done || din.buffer_end)
        begin
            phase_next = PH_TAG;
            left_next  = '0;
            pos_next   = '0;
            accum_next = 32'd0;
            vpos_next  = 32'd0;
        end
    end

    // Output stage next values.
    always_comb
    begin
        main_next       = main_reg;
        skid_next       = skid_reg;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (!main_valid_reg || pop)
            begin
                main_next       = res;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_TAG;
            tag_reg        <= '0;
            ptr_reg        <= 1'b0;
            left_reg       <= '0;
            pos_reg        <= '0;
            accum_reg      <= '0;
            vpos_reg       <= '0;
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                tag_reg   <= tag_next;
                ptr_reg   <= ptr_next;
                left_reg  <= left_next;
                pos_reg   <= pos_next;
                accum_reg <= accum_next;
                vpos_reg  <= vpos_next;
            end
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign dout.valid         = main_valid_reg;
    assign dout.byte_kind     = main_reg.byte_kind;
    assign dout.record_tag    = main_reg.record_tag;
    assign dout.pointer_flag  = main_reg.pointer_flag;
    assign dout.payload_byte  = main_reg.payload_byte;
    assign dout.value_index   = main_reg.value_index;
    assign dout.record_length = main_reg.record_length;
    assign dout.record_done   = main_reg.record_done;
    assign dout.status        = main_reg.status;

endmodule

>>> design/tlvd_checker.sv
module tlvd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  byte_kind,
    input logic [31:0] value_index,
    input logic [31:0] record_length,
    input logic        record_done,
    input logic        status,
    input logic [7:0]  payload_byte
);
    import tlvd_pkg::*;

    // A stalled word stays on the port.
    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("dout.valid dropped while stalled");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(payload_byte) && $stable(byte_kind))
        else $error("dout word changed while stalled");

    // A completed record is never reported as truncated.
    a_done_not_trunc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && record_done |-> !status)
        else $error("record_done together with truncation status");

    // A tag byte starts a record: nothing decoded yet, record not complete.
    a_tag_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_kind == KIND_TAG |->
            !record_done && value_index == 32'd0 && record_length == 32'd0)
        else $error("tag word carries record data");

    // The last value byte of a record sits at offset length minus one.
    a_last_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_kind == KIND_VALUE && record_done |->
            value_index + 32'd1 == record_length)
        else $error("value byte ended record at wrong offset");

endmodule

bind tlv_stream_deframer tlvd_checker u_tlvd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (dout.valid),
    .out_ready     (dout.ready),
    .byte_kind     (dout.byte_kind),
    .value_index   (dout.value_index),
    .record_length (dout.record_length),
    .record_done   (dout.record_done),
    .status        (dout.status),
    .payload_byte  (dout.payload_byte)
);
